[rtl/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
// Holds the request and result payloads, the front-to-back command and the back-end states.
// Depends on nothing.
package tcw_pkg;

	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int CMD_ADDR_W = 13;
	localparam int CMD_ROW_W  = 6;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_BEL = 8'd7;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] BLANK_ATTR = 8'h07;

	typedef struct packed {
		logic             req_type;
		logic [7:0]       char_code;
		logic             write_attr;
		logic [7:0]       attr_byte;
		logic [COL_W-1:0] read_col;
		logic [ROW_W-1:0] read_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
	} out_item_t;

	typedef struct packed {
		logic                  do_read;
		logic                  wr_char;
		logic                  wr_attr;
		logic                  scroll;
		logic [7:0]            char_data;
		logic [7:0]            attr_data;
		logic [CMD_ADDR_W-1:0] addr;
		logic [CMD_ROW_W-1:0]  clr_row;
		logic [COL_W-1:0]      cursor_col;
		logic [ROW_W-1:0]      cursor_row;
	} cmd_t;

	typedef enum logic {
		BK_CLEAR,
		BK_RUN
	} bk_state_t;

endpackage

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tcw_front.sv]
// Front end: takes requests, applies the teletype cursor rules and issues cell commands.
// Owns the cursor and the circular top-row pointer. Depends on tcw_pkg.
module tcw_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcw_pkg::in_item_t in_data,
	input  logic              init_done,
	input  logic              q_full,
	output logic              q_push,
	output tcw_pkg::cmd_t     q_cmd
);
	import tcw_pkg::*;

	localparam int CW = $clog2(COLS);
	localparam int RW = $clog2(ROWS);
	localparam int AW = $clog2(ROWS * COLS);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

	logic [CW-1:0] col_q, n_col, cell_col;
	logic [RW-1:0] row_q, n_row, cell_row;
	logic [RW-1:0] top_q, n_top, phys_row;
	logic [RW:0]   phys_sum;
	logic [AW-1:0] addr;
	logic [7:0]    wchar;
	logic          lf_req, scroll, wr_char, wr_attr, do_read, in_range;

	assign in_ready = init_done && !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		n_col    = col_q;
		n_row    = row_q;
		n_top    = top_q;
		lf_req   = 1'b0;
		scroll   = 1'b0;
		wr_char  = 1'b0;
		wr_attr  = 1'b0;
		do_read  = 1'b0;
		cell_col = col_q;
		cell_row = row_q;
		wchar    = in_data.char_code;
		in_range = (int'(in_data.read_col) < COLS) && (int'(in_data.read_row) < ROWS);
		if (in_data.req_type == REQ_READ) begin
			do_read  = in_range;
			cell_col = CW'(in_data.read_col);
			cell_row = RW'(in_data.read_row);
		end else begin
			case (in_data.char_code)
				CH_CR: begin
					n_col = '0;
				end
				CH_LF: begin
					lf_req = 1'b1;
				end
				CH_BS: begin
					// step back, wrapping to the previous row; row 0 stays put
					if (col_q == '0) begin
						n_col = COL_LAST;
						if (row_q != '0) begin
							n_row = row_q - 1'b1;
						end
					end else begin
						n_col = col_q - 1'b1;
					end
					cell_col = n_col;
					cell_row = n_row;
					wr_char  = 1'b1;
					wchar    = BLANK_CHAR;
				end
				CH_BEL: begin
				end
				default: begin
					wr_char = 1'b1;
					wr_attr = in_data.write_attr;
					if (col_q == COL_LAST) begin
						n_col  = '0;
						lf_req = 1'b1;
					end else begin
						n_col = col_q + 1'b1;
					end
				end
			endcase
			if (lf_req) begin
				if (row_q == ROW_LAST) begin
					scroll = !in_data.write_attr;
				end else begin
					n_row = row_q + 1'b1;
				end
			end
			if (scroll) begin
				n_top = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
			end
		end
		// logical row to physical row through the circular top pointer
		phys_sum = {1'b0, cell_row} + {1'b0, top_q};
		if (int'(phys_sum) >= ROWS) begin
			phys_row = RW'(int'(phys_sum) - ROWS);
		end else begin
			phys_row = RW'(phys_sum);
		end
		addr = AW'(int'(phys_row) * COLS + int'(cell_col));
	end

	always_comb begin
		q_cmd.do_read    = do_read;
		q_cmd.wr_char    = wr_char;
		q_cmd.wr_attr    = wr_attr;
		q_cmd.scroll     = scroll;
		q_cmd.char_data  = wchar;
		q_cmd.attr_data  = in_data.attr_byte;
		q_cmd.addr       = CMD_ADDR_W'(addr);
		q_cmd.clr_row    = CMD_ROW_W'(top_q);
		q_cmd.cursor_col = COL_W'(n_col);
		q_cmd.cursor_row = ROW_W'(n_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			top_q <= '0;
		end else if (q_push) begin
			col_q <= n_col;
			row_q <= n_row;
			top_q <= n_top;
		end
	end

endmodule

[rtl/tcw_queue.sv]
// Short command queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output tcw_pkg::cmd_t head
);
	import tcw_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tcw_back.sv]
// Back end: carries out cell commands on the character and attribute RAMs,
// clears the screen after reset and the recycled row after a scroll, drives the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tcw_pkg::cmd_t      q_cmd,
	output logic               q_pop,
	output logic               init_done,
	output logic               out_valid,
	input  logic               out_ready,
	output tcw_pkg::out_item_t out_data
);
	import tcw_pkg::*;

	localparam int AW = $clog2(ROWS * COLS);

	bk_state_t     state_q, state_d;
	logic [AW-1:0] clr_addr_q, clr_addr_d, clr_last_q, clr_last_d;
	logic          init_done_q, init_done_d;
	logic          valid_s1, is_read_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic          out_valid_q;
	out_item_t     out_data_q;
	logic          s1_adv, s1_free;
	logic          we_char, we_attr, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata_char, wdata_attr, rdata_char, rdata_attr;

	assign s1_adv    = !out_valid_q || out_ready;
	assign s1_free   = !valid_s1 || s1_adv;
	assign init_done = init_done_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		state_d     = state_q;
		clr_addr_d  = clr_addr_q;
		clr_last_d  = clr_last_q;
		init_done_d = init_done_q;
		q_pop       = 1'b0;
		we_char     = 1'b0;
		we_attr     = 1'b0;
		re          = 1'b0;
		waddr       = AW'(q_cmd.addr);
		raddr       = AW'(q_cmd.addr);
		wdata_char  = q_cmd.char_data;
		wdata_attr  = q_cmd.attr_data;
		case (state_q)
			BK_CLEAR: begin
				we_char    = 1'b1;
				we_attr    = 1'b1;
				waddr      = clr_addr_q;
				wdata_char = BLANK_CHAR;
				wdata_attr = BLANK_ATTR;
				if (clr_addr_q == clr_last_q) begin
					state_d     = BK_RUN;
					init_done_d = 1'b1;
				end else begin
					clr_addr_d = clr_addr_q + 1'b1;
				end
			end
			BK_RUN: begin
				q_pop = q_valid && s1_free;
				if (q_pop) begin
					we_char = q_cmd.wr_char;
					we_attr = q_cmd.wr_attr;
					re      = q_cmd.do_read;
					if (q_cmd.scroll) begin
						clr_addr_d = AW'(int'(q_cmd.clr_row) * COLS);
						clr_last_d = AW'(int'(q_cmd.clr_row) * COLS + COLS - 1);
						state_d    = BK_CLEAR;
					end
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			clr_last_q  <= AW'(ROWS * COLS - 1);
			init_done_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_addr_q  <= clr_addr_d;
			clr_last_q  <= clr_last_d;
			init_done_q <= init_done_d;
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			is_read_s1 <= q_cmd.do_read;
			col_s1     <= q_cmd.cursor_col;
			row_s1     <= q_cmd.cursor_row;
		end
		if (valid_s1 && s1_adv) begin
			out_data_q.cell_char  <= is_read_s1 ? rdata_char : 8'h00;
			out_data_q.cell_attr  <= is_read_s1 ? rdata_attr : 8'h00;
			out_data_q.cursor_col <= col_s1;
			out_data_q.cursor_row <= row_s1;
		end
	end

	tcw_ram #(
		.WIDTH(8),
		.DEPTH(ROWS * COLS)
	) u_char_ram (
		.clk  (clk),
		.we   (we_char),
		.waddr(waddr),
		.wdata(wdata_char),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata_char)
	);

	tcw_ram #(
		.WIDTH(8),
		.DEPTH(ROWS * COLS)
	) u_attr_ram (
		.clk  (clk),
		.we   (we_attr),
		.waddr(waddr),
		.wdata(wdata_attr),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata_attr)
	);

endmodule

[rtl/text_console_char_writer.sv]
// Top level of the text console character writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (and tcw_ram through the back end).
//
//   channel   handshake              payload    carries
//   request   in_valid / in_ready    in_data    write at cursor or read one cell
//   result    out_valid / out_ready  out_data   cell bytes (reads) and cursor
//
// Every request gives exactly one result. The back end handles one command per cycle
// while it is not blanking and the result register is not held. A command goes from
// the queue through stage 1 (the RAM read) into the result register. A scroll makes
// the back end blank the recycled row (the screen is a circular set of rows, so
// nothing is copied). After reset the back end blanks all ROWS*COLS cells, one per
// cycle, with in_ready held low. Either side may stall: the queue lets the front end
// keep taking requests while the back end is blanking or the result register waits.
module text_console_char_writer #(
	parameter int COLS        = 80,
	parameter int ROWS        = 25,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcw_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tcw_pkg::out_item_t out_data
);
	import tcw_pkg::*;

	// front-to-back command path
	cmd_t push_cmd, head_cmd;
	logic q_push, q_full, q_pop, q_valid;
	// low until the power-up blanking pass is done
	logic init_done;

	// classify the request and advance the cursor
	tcw_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.init_done(init_done),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// hold commands while the back end is busy
	tcw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	// carry out cell writes, reads and blanking; drive the result register
	tcw_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (head_cmd),
		.q_pop    (q_pop),
		.init_done(init_done),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// no request may enter before the screen has been blanked
	a_no_accept_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> init_done)
		else $error("request accepted during power-up blanking");

	// the front end must never overrun the queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	// the queue may only be popped when it holds a command
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from an empty queue");

	// reported cursor column stays on screen
	a_cursor_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_data.cursor_col) < COLS))
		else $error("cursor column off screen");
`endif

endmodule
